### src/global_to_local_renumbering_assert.svh
// assertion macros for the global to local renumbering block
`ifndef GLOBAL_TO_LOCAL_RENUMBERING_ASSERT_SVH
`define GLOBAL_TO_LOCAL_RENUMBERING_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GTLR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtlr check failed");
`define GTLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtlr check failed");
`else
`define GTLR_ASSERT(lbl, ante, cons)
`define GTLR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/gtlr_pkg.sv
// types and constants for the global to local renumbering block
package gtlr_pkg;

  localparam int GLOBAL_BITS_DEF    = 16;
  localparam int LOCAL_CAPACITY_DEF = 65536;

  localparam int ID_W       = 16;
  localparam int COUNT_W    = 17;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_REV   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_REV,
    S_DONE
  } state_t;

endpackage

### src/global_to_local_renumbering.sv
// global to local id renumbering block with table memories and control sequencer
//
// Renumbers sparse global ids into dense local ids in first-seen order. Two synchronous
// tables hold the mapping: local_of_global (2**GLOBAL_BITS entries) and global_of_local
// (LOCAL_CAPACITY entries). An id counts as seen when its local entry is below the count
// and the inverse entry points back to it, so a clear request takes effect at once and
// needs no sweep. After reset the block runs a pass over all 2**GLOBAL_BITS entries that
// zeroes local_of_global and accepts no request during it. One request is handled at a
// time: a map passes through S_LOOK and S_CHECK (two dependent table reads, then the
// update) before S_DONE loads its result into the output register, a reverse read passes
// through S_REV and a clear or unused opcode goes straight to S_DONE, which waits while
// the output register is still full; the next request is accepted in the cycle after
// the result is loaded.
`include "global_to_local_renumbering_assert.svh"

module global_to_local_renumbering
  import gtlr_pkg::*;
#(
  parameter int GLOBAL_BITS    = GLOBAL_BITS_DEF,
  parameter int LOCAL_CAPACITY = LOCAL_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // global_id[15:0], local_index[31:16]
  input  logic [OP_W-1:0]       in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // local_id[15:0], is_new[16], overflow[17], unique_count[34:18], min_global[50:35],
  // largest_id[66:51], any_seen[67], global_of_local[83:68], index_valid[84], zero[87:85]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int GB     = GLOBAL_BITS;
  localparam int LW     = (LOCAL_CAPACITY > 1) ? $clog2(LOCAL_CAPACITY) : 1;
  localparam int CW     = LW + 1;
  localparam int GDEPTH = 1 << GLOBAL_BITS;

  state_t state_r, state_nxt;

  logic [GB-1:0] init_addr_r, init_addr_nxt;
  logic [GB-1:0] g_r, g_nxt;
  logic          cand_r, cand_nxt;
  logic [LW-1:0] lid_r, lid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [GB-1:0] min_r, min_nxt;
  logic [GB-1:0] max_r, max_nxt;
  logic          ovf_r, ovf_nxt;

  logic [LW-1:0] res_lid_r, res_lid_nxt;
  logic          res_new_r, res_new_nxt;
  logic [GB-1:0] res_gol_r, res_gol_nxt;
  logic          res_valid_r, res_valid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // table memories
  logic [LW-1:0] lof_mem [GDEPTH];
  logic [GB-1:0] gol_mem [LOCAL_CAPACITY];
  logic [LW-1:0] lof_q;
  logic [GB-1:0] gol_q;

  logic          lof_we;
  logic [GB-1:0] lof_wa, lof_ra;
  logic [LW-1:0] lof_wd;
  logic          gol_we;
  logic [LW-1:0] gol_wa, gol_ra;
  logic [GB-1:0] gol_wd;

  logic          in_fire;
  logic          out_free;
  logic [GB-1:0] in_gid;
  logic [ID_W-1:0] in_lidx;
  logic          rev_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign in_gid     = GB'(in_tdata[15:0]);
  assign in_lidx    = in_tdata[31:16];
  assign rev_ok     = 32'(in_lidx) < 32'(count_r);

  always_ff @(posedge clk) begin
    if (lof_we) begin
      lof_mem[lof_wa] <= lof_wd;
    end
    lof_q <= lof_mem[lof_ra];
  end

  always_ff @(posedge clk) begin
    if (gol_we) begin
      gol_mem[gol_wa] <= gol_wd;
    end
    gol_q <= gol_mem[gol_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (init_addr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            OP_MAP:  state_nxt = S_LOOK;
            OP_REV:  state_nxt = S_REV;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOK:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_DONE;
      S_REV:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath and table control
  always_comb begin
    init_addr_nxt = init_addr_r;
    g_nxt         = g_r;
    cand_nxt      = cand_r;
    lid_nxt       = lid_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ovf_nxt       = ovf_r;
    res_lid_nxt   = res_lid_r;
    res_new_nxt   = res_new_r;
    res_gol_nxt   = res_gol_r;
    res_valid_nxt = res_valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    lof_we        = 1'b0;
    lof_wa        = g_r;
    lof_wd        = LW'(count_r);
    lof_ra        = in_gid;
    gol_we        = 1'b0;
    gol_wa        = LW'(count_r);
    gol_wd        = g_r;
    gol_ra        = LW'(in_lidx);
    case (state_r)
      S_INIT: begin
        lof_we        = 1'b1;
        lof_wa        = init_addr_r;
        lof_wd        = '0;
        init_addr_nxt = init_addr_r + 1'b1;
      end
      S_IDLE: begin
        g_nxt         = in_gid;
        res_lid_nxt   = '0;
        res_new_nxt   = 1'b0;
        res_gol_nxt   = '0;
        res_valid_nxt = 1'b0;
        if (in_fire) begin
          case (in_tuser)
            OP_REV: res_valid_nxt = rev_ok;
            OP_CLEAR: begin
              count_nxt = '0;
              min_nxt   = '1;
              max_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        gol_ra   = lof_q;
        lid_nxt  = lof_q;
        cand_nxt = {1'b0, lof_q} < count_r;
      end
      S_CHECK: begin
        if (cand_r && (gol_q == g_r)) begin
          res_lid_nxt = lid_r;
        end else if (count_r >= CW'(LOCAL_CAPACITY)) begin
          ovf_nxt = 1'b1;
        end else begin
          lof_we      = 1'b1;
          gol_we      = 1'b1;
          count_nxt   = count_r + 1'b1;
          res_lid_nxt = LW'(count_r);
          res_new_nxt = 1'b1;
          if (g_r < min_r) min_nxt = g_r;
          if (g_r > max_r) max_nxt = g_r;
        end
      end
      S_REV: begin
        if (res_valid_r) res_gol_nxt = gol_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {3'b000, res_valid_r, ID_W'(res_gol_r), (count_r != '0),
                           ID_W'(max_r), ID_W'(min_r), COUNT_W'(count_r), ovf_r,
                           res_new_r, ID_W'(res_lid_r)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      count_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r         <= g_nxt;
    cand_r      <= cand_nxt;
    lid_r       <= lid_nxt;
    res_lid_r   <= res_lid_nxt;
    res_new_r   <= res_new_nxt;
    res_gol_r   <= res_gol_nxt;
    res_valid_r <= res_valid_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  `GTLR_ASSERT(a_count_cap, 1'b1, count_r <= CW'(LOCAL_CAPACITY))
  `GTLR_ASSERT(a_min_le_max, count_r != '0, min_r <= max_r)
  `GTLR_ASSERT_NEXT(a_count_step, gol_we, count_r == $past(count_r) + 1'b1)
  `GTLR_ASSERT_NEXT(a_ovf_sticky, ovf_r && !(in_fire && (in_tuser == OP_CLEAR)), ovf_r)

endmodule

### tb/sv/tb_top.sv
// self-checking stream testbench for the global to local id renumbering block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gtlr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ID_SPACE = 1 << GLOBAL_BITS_DEF;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] local_index;
    logic [ID_W-1:0] global_id;
  } renum_req_t;

  typedef struct packed {
    logic               index_valid;
    logic [ID_W-1:0]    global_of_local;
    logic               any_seen;
    logic [ID_W-1:0]    largest_id;
    logic [ID_W-1:0]    min_global;
    logic [COUNT_W-1:0] unique_count;
    logic               overflow;
    logic               is_new;
    logic [ID_W-1:0]    local_id;
  } renum_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  global_to_local_renumbering dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the renumbering state
  bit                 seen_tbl [ID_SPACE];
  logic [ID_W-1:0]    loc_tbl [ID_SPACE];
  logic [ID_W-1:0]    glob_tbl [LOCAL_CAPACITY_DEF];
  logic [COUNT_W-1:0] id_count = '0;
  logic [ID_W-1:0]    min_id = '1;
  logic [ID_W-1:0]    max_id = '0;
  bit                 overflow_seen = 1'b0;

  renum_req_t    pending_reqs[$];
  renum_result_t expected_results[$];
  renum_req_t    req_on_wire;
  bit            req_on_bus = 1'b0;
  bit            idle_on = 1'b1;
  int            src_gap = 0;
  int            sink_gap = 0;
  int            mismatches = 0;
  renum_result_t got_res;
  renum_result_t want_res;

  function automatic renum_result_t renumber_step(renum_req_t r);
    renum_result_t res;
    res = '0;
    case (r.op)
      OP_MAP: begin
        if (seen_tbl[r.global_id]) begin
          res.local_id = loc_tbl[r.global_id];
        end else if (id_count >= LOCAL_CAPACITY_DEF) begin
          overflow_seen = 1'b1;
        end else begin
          res.local_id = id_count[ID_W-1:0];
          res.is_new = 1'b1;
          seen_tbl[r.global_id] = 1'b1;
          loc_tbl[r.global_id] = id_count[ID_W-1:0];
          glob_tbl[id_count[ID_W-1:0]] = r.global_id;
          id_count = id_count + 1'b1;
          if (r.global_id < min_id) min_id = r.global_id;
          if (r.global_id > max_id) max_id = r.global_id;
        end
      end
      OP_REV: begin
        if (id_count > r.local_index) begin
          res.index_valid = 1'b1;
          res.global_of_local = glob_tbl[r.local_index];
        end
      end
      OP_CLEAR: begin
        foreach (seen_tbl[i]) seen_tbl[i] = 1'b0;
        id_count = '0;
        min_id = '1;
        max_id = '0;
        overflow_seen = 1'b0;
      end
      default: ;
    endcase
    res.overflow = overflow_seen;
    res.unique_count = id_count;
    res.min_global = min_id;
    res.largest_id = max_id;
    res.any_seen = (id_count != 0);
    return res;
  endfunction

  function automatic string show_result(renum_result_t r);
    return $sformatf({"local_id=%0d is_new=%0b overflow=%0b count=%0d min=%0d max=%0d ",
                      "any_seen=%0b global_of_local=%0d index_valid=%0b"},
                     r.local_id, r.is_new, r.overflow, r.unique_count, r.min_global,
                     r.largest_id, r.any_seen, r.global_of_local, r.index_valid);
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [ID_W-1:0] gid, logic [ID_W-1:0] lidx);
    renum_req_t r;
    r.op = op;
    r.global_id = gid;
    r.local_index = lidx;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_on_bus || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(renumber_step(req_on_wire));
        req_on_bus = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 6);
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_on_wire = pending_reqs.pop_front();
          req_on_bus = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata <= {req_on_wire.local_index, req_on_wire.global_id};
          in_tuser <= req_on_wire.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = renum_result_t'(out_tdata[$bits(renum_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show_result(got_res));
        end else begin
          want_res = expected_results.pop_front();
          if (got_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %s", show_result(want_res));
              $display("          actual   %s", show_result(got_res));
            end
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] set_ids[$];
    logic [ID_W-1:0] gid;
    logic [ID_W-1:0] lidx;
    int unsigned     pick;
    int unsigned     stride;
    int unsigned     offs;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty set, unused opcode, extremes
    add_req(OP_REV, 16'h0000, 16'h0000);
    add_req(OP_REV, 16'hFFFF, 16'hFFFF);
    add_req(OP_UNUSED, 16'h0000, 16'h0000);
    add_req(OP_MAP, 16'h8000, 16'hFFFF);
    add_req(OP_MAP, 16'h0000, 16'h0000);
    add_req(OP_MAP, 16'hFFFF, 16'h1234);
    add_req(OP_MAP, 16'h8000, 16'h0000);
    add_req(OP_MAP, 16'h5555, 16'hAAAA);
    add_req(OP_MAP, 16'hAAAA, 16'h5555);
    add_req(OP_MAP, 16'h0000, 16'hFFFF);
    add_req(OP_REV, 16'hFFFF, 16'h0000);
    add_req(OP_REV, 16'h0000, 16'h0001);
    add_req(OP_REV, 16'h1234, 16'h0002);
    add_req(OP_REV, 16'h0000, 16'h0004);
    add_req(OP_REV, 16'h0000, 16'h0005);
    add_req(OP_REV, 16'h0000, 16'hFFFF);
    add_req(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    add_req(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    add_req(OP_REV, 16'h0000, 16'h0000);
    add_req(OP_MAP, 16'h1234, 16'h0000);
    add_req(OP_REV, 16'h0000, 16'h0000);
    add_req(OP_CLEAR, 16'h0000, 16'h0000);
    add_req(OP_MAP, 16'hFFFF, 16'h0000);
    add_req(OP_MAP, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // random traffic: mostly maps and read-backs within the current set
    for (int n = 0; n < 820; n++) begin
      pick = $urandom_range(0, 99);
      gid = 16'($urandom);
      lidx = 16'($urandom);
      if (pick < 40) begin
        add_req(OP_MAP, gid, lidx);
        set_ids.push_back(gid);
      end else if (pick < 65 && set_ids.size() != 0) begin
        add_req(OP_MAP, set_ids[$urandom_range(0, set_ids.size() - 1)], lidx);
      end else if (pick < 72) begin
        gid = 16'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) gid = ~gid;
        add_req(OP_MAP, gid, lidx);
        set_ids.push_back(gid);
      end else if (pick < 94) begin
        if ($urandom_range(0, 4) != 0) lidx = 16'($urandom_range(0, set_ids.size()));
        add_req(OP_REV, gid, lidx);
      end else if (pick < 97) begin
        add_req(OP_UNUSED, gid, lidx);
      end else begin
        add_req(OP_CLEAR, gid, lidx);
        set_ids.delete();
      end
    end

    // sender holds until every result is back
    wait_drained();

    // strided set of distinct ids, no idling from here on
    idle_on = 1'b0;
    add_req(OP_CLEAR, 16'($urandom), 16'($urandom));
    stride = $urandom | 1;
    offs = $urandom_range(0, ID_SPACE - 1);
    for (int i = 0; i < 48; i++)
      add_req(OP_MAP, 16'(i * stride + offs), 16'($urandom));
    add_req(OP_MAP, 16'(offs), 16'($urandom));
    add_req(OP_MAP, 16'h0000, 16'h0000);
    add_req(OP_MAP, 16'hFFFF, 16'hFFFF);
    add_req(OP_REV, 16'($urandom), 16'hFFFF);
    add_req(OP_REV, 16'($urandom), 16'h0000);
    add_req(OP_UNUSED, 16'($urandom), 16'($urandom));
    add_req(OP_CLEAR, 16'($urandom), 16'($urandom));
    add_req(OP_REV, 16'($urandom), 16'hFFFF);
    add_req(OP_MAP, 16'h0000, 16'h0000);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
